// ===== rtl/core/bof_pkg.sv =====
// ----------------------------------------------------------------------------
// bof_pkg
// shared types and constants for the bulk-out transfer framer
// ----------------------------------------------------------------------------
package bof_pkg;

  // input action codes
  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_BYTE    = 2'd1,
    ACT_REQUEST = 2'd2
  } bof_action_e;

  // kind of work handed from front to back
  typedef enum logic {
    CMD_HEADER  = 1'b0,
    CMD_PAYLOAD = 1'b1
  } bof_kind_e;

  localparam logic [7:0] ID_MSG_OUT = 8'h01;
  localparam logic [7:0] ID_REQ_IN  = 8'h02;
  localparam logic [7:0] ATTR_EOM   = 8'h01;
  localparam logic [7:0] ATTR_TERM  = 8'h02;

  localparam int unsigned HdrLen    = 12;
  localparam int unsigned BeatCntW  = $clog2(HdrLen);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // one unit of work for the back end
  typedef struct packed {
    bof_kind_e   kind;
    logic [7:0]  id;
    logic [7:0]  tag;
    logic [31:0] size;
    logic [7:0]  attr;
    logic [7:0]  b9;
    logic [7:0]  data;
    logic [1:0]  pads;
    logic        fin;   // final beat of this command closes the transfer
  } bof_cmd_t;

  // queue status seen by front end and checks
  typedef struct packed {
    logic full;
    logic empty;
  } bof_qstat_t;

endpackage

// ===== rtl/core/bulk_out_transfer_framer.sv =====
// ----------------------------------------------------------------------------
// bulk_out_transfer_framer
// usbtmc bulk-out framing: message and request-in headers, payload, pads
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  input    | in_valid_i/in_ready_o  | action, tag, transfer_size, eom,
//           |                        | term_char, use_term_char, data_byte
//  output   | out_valid_o/out_ready_i| out_byte, last
//
//  a header item yields 12 output beats, one per cycle unless out_ready_i
//  stalls; a payload byte yields one beat, the final one plus up to three
//  zero pads; an item's first beat goes through the command queue and then
//  the back end's output register, which sets the rate: one output beat per
//  cycle while work is queued and out_ready_i is high; input stalls only
//  when the two-entry command queue is full; reset clears message tracking,
//  the queue pointers and the output valid flag
module bulk_out_transfer_framer
  import bof_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  tag_i,
  input  logic [31:0] transfer_size_i,
  input  logic        end_of_message_i,
  input  logic [7:0]  term_char_i,
  input  logic        use_term_char_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  // front to queue
  logic       push;
  bof_cmd_t   push_cmd;
  // queue to back
  bof_cmd_t   head_cmd;
  bof_qstat_t qstat;
  logic       pop;

  // front end: classifies items and tracks the open message
  bof_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .action_i,
    .tag_i,
    .transfer_size_i,
    .end_of_message_i,
    .term_char_i,
    .use_term_char_i,
    .data_byte_i,
    .qstat_i (qstat),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  // decoupling queue
  bof_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .stat_o (qstat)
  );

  // back end: beat sequencing and output register
  bof_back u_back (
    .clk_i,
    .rst_ni,
    .head_i  (head_cmd),
    .qstat_i (qstat),
    .pop_o   (pop),
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .last_o
  );

  // queue never written while full
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !qstat.full)
    else $error("command pushed into full queue");

  // back end never retires a command that is not there
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !qstat.empty)
    else $error("command popped from empty queue");

  // queue status stays consistent
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(qstat.full && qstat.empty))
    else $error("queue both full and empty");

  // a retired command leaves a beat in the output register next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |=> out_valid_o)
    else $error("retired command produced no output beat");

endmodule

// ===== rtl/core/bof_front.sv =====
// ----------------------------------------------------------------------------
// bof_front
// accepts input items, tracks the open message and queues back-end work
// ----------------------------------------------------------------------------
module bof_front
  import bof_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  tag_i,
  input  logic [31:0] transfer_size_i,
  input  logic        end_of_message_i,
  input  logic [7:0]  term_char_i,
  input  logic        use_term_char_i,
  input  logic [7:0]  data_byte_i,
  input  bof_qstat_t  qstat_i,
  output logic        push_o,
  output bof_cmd_t    cmd_o
);

  logic [31:0] remain_q, remain_d;
  logic [1:0]  pad_q, pad_d;
  logic        open_q, open_d;
  logic        accept;
  logic        last_byte;

  assign in_ready_o = ~qstat_i.full;
  assign accept     = in_valid_i & in_ready_o;
  assign last_byte  = (remain_q == 32'd1);

  always_comb begin
    remain_d = remain_q;
    pad_d    = pad_q;
    open_d   = open_q;
    push_o   = 1'b0;
    cmd_o    = '0;
    cmd_o.tag  = tag_i;
    cmd_o.size = transfer_size_i;
    cmd_o.data = data_byte_i;
    if (accept) begin
      unique case (action_i)
        ACT_START: begin
          remain_d   = transfer_size_i;
          pad_d      = 2'(~transfer_size_i[1:0] + 2'd1);
          open_d     = (transfer_size_i != 32'd0);
          push_o     = 1'b1;
          cmd_o.kind = CMD_HEADER;
          cmd_o.id   = ID_MSG_OUT;
          cmd_o.attr = end_of_message_i ? ATTR_EOM : 8'h00;
          cmd_o.b9   = 8'h00;
          cmd_o.fin  = (transfer_size_i == 32'd0);
        end
        ACT_REQUEST: begin
          remain_d   = '0;
          pad_d      = '0;
          open_d     = 1'b0;
          push_o     = 1'b1;
          cmd_o.kind = CMD_HEADER;
          cmd_o.id   = ID_REQ_IN;
          cmd_o.attr = use_term_char_i ? ATTR_TERM : 8'h00;
          cmd_o.b9   = use_term_char_i ? term_char_i : 8'h00;
          cmd_o.fin  = 1'b1;
        end
        ACT_BYTE: begin
          // bytes outside a message are dropped
          if (open_q && (remain_q != 32'd0)) begin
            remain_d   = remain_q - 32'd1;
            push_o     = 1'b1;
            cmd_o.kind = CMD_PAYLOAD;
            cmd_o.pads = last_byte ? pad_q : 2'd0;
            cmd_o.fin  = last_byte;
            if (last_byte) begin
              pad_d  = '0;
              open_d = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
      pad_q    <= '0;
      open_q   <= 1'b0;
    end else begin
      remain_q <= remain_d;
      pad_q    <= pad_d;
      open_q   <= open_d;
    end
  end

endmodule

// ===== rtl/core/bof_queue.sv =====
// ----------------------------------------------------------------------------
// bof_queue
// short command queue between front and back ends
// ----------------------------------------------------------------------------
module bof_queue
  import bof_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  bof_cmd_t   cmd_i,
  input  logic       pop_i,
  output bof_cmd_t   head_o,
  output bof_qstat_t stat_o
);

  bof_cmd_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]   cnt_q;
  logic                   do_push, do_pop;

  assign stat_o.full  = (cnt_q == QueueCntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QueueCntW'(do_push) - QueueCntW'(do_pop);
    end
  end

endmodule

// ===== rtl/core/bof_back.sv =====
// ----------------------------------------------------------------------------
// bof_back
// expands queued commands into output beats through an output register
// ----------------------------------------------------------------------------
module bof_back
  import bof_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bof_cmd_t   head_i,
  input  bof_qstat_t qstat_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic [BeatCntW-1:0] beat_q, beat_d;
  logic                valid_q, valid_d;
  logic [7:0]          byte_q, byte_d;
  logic                last_q, last_d;
  logic                load;
  logic                beat_end;
  logic [7:0]          hdr_byte;

  assign load = ~qstat_i.empty & (~valid_q | out_ready_i);

  // header byte for the current beat
  always_comb begin
    case (beat_q)
      4'd0:    hdr_byte = head_i.id;
      4'd1:    hdr_byte = head_i.tag;
      4'd2:    hdr_byte = ~head_i.tag;
      4'd4:    hdr_byte = head_i.size[7:0];
      4'd5:    hdr_byte = head_i.size[15:8];
      4'd6:    hdr_byte = head_i.size[23:16];
      4'd7:    hdr_byte = head_i.size[31:24];
      4'd8:    hdr_byte = head_i.attr;
      4'd9:    hdr_byte = head_i.b9;
      default: hdr_byte = 8'h00;
    endcase
  end

  always_comb begin
    if (head_i.kind == CMD_HEADER) begin
      beat_end = (beat_q == BeatCntW'(HdrLen - 1));
    end else begin
      beat_end = (beat_q[1:0] == head_i.pads);
    end
  end

  assign pop_o = load & beat_end;

  always_comb begin
    beat_d  = beat_q;
    valid_d = valid_q & ~out_ready_i;
    byte_d  = byte_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      last_d  = head_i.fin & beat_end;
      beat_d  = beat_end ? '0 : beat_q + 1'b1;
      if (head_i.kind == CMD_HEADER) begin
        byte_d = hdr_byte;
      end else begin
        // payload byte first, zero pads after it
        byte_d = (beat_q == '0) ? head_i.data : 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      beat_q  <= beat_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for bulk_out_transfer_framer: a directed table of
// headers, payload bytes and edge cases, then random message traffic with
// bursty input and a stalling receiver, every output beat scored in order
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bof_pkg::*;

  // the one action code the package leaves unnamed, must be ignored
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int unsigned WordBytes    = 4;
  localparam int unsigned RandomItems  = 160;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned MaxReported  = 10;

  // one input beat, field for field
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  tag;
    logic [31:0] size;
    logic        eom;
    logic [7:0]  tchar;
    logic        use_tc;
    logic [7:0]  data;
  } framer_item_t;

  // one output beat
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } beat_t;

  // directed row: typed rows carry their beats, first byte in the top octet
  typedef struct packed {
    framer_item_t item;
    logic         typed;
    logic [3:0]   n;
    logic [95:0]  bytes;
    logic         fin;
  } dir_row_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i         = '0;
  logic [7:0]  tag_i            = '0;
  logic [31:0] transfer_size_i  = '0;
  logic        end_of_message_i = 1'b0;
  logic [7:0]  term_char_i      = '0;
  logic        use_term_char_i  = 1'b0;
  logic [7:0]  data_byte_i      = '0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_o;

  // typed expectation riding along with the driven beat
  logic        row_typed = 1'b0;
  logic [3:0]  row_n     = '0;
  logic [95:0] row_bytes = '0;
  logic        row_fin   = 1'b0;

  // framing state mirrored by the predictor
  logic [31:0] msg_left = '0;
  logic [1:0]  msg_pads = '0;
  logic        msg_open = 1'b0;

  beat_t       framed_beats [$];   // beats produced by the last predicted item
  beat_t       owed_beats [$];     // beats the block still owes, oldest first
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;
  bit          hold_off_req   = 1'b0;

  bulk_out_transfer_framer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .tag_i            (tag_i),
    .transfer_size_i  (transfer_size_i),
    .end_of_message_i (end_of_message_i),
    .term_char_i      (term_char_i),
    .use_term_char_i  (use_term_char_i),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o)
  );

  always #6 clk_i = ~clk_i;

  // twelve header bytes: id, tag, ~tag, 0, size little-endian, attr, b9, 0, 0
  function automatic void push_header(input logic [7:0] id, input logic [7:0] tag,
                                      input logic [31:0] size, input logic [7:0] attr,
                                      input logic [7:0] b9, input logic fin);
    logic [7:0] hdr [HdrLen];
    hdr[0]  = id;
    hdr[1]  = tag;
    hdr[2]  = ~tag;
    hdr[3]  = 8'h00;
    hdr[4]  = size[7:0];
    hdr[5]  = size[15:8];
    hdr[6]  = size[23:16];
    hdr[7]  = size[31:24];
    hdr[8]  = attr;
    hdr[9]  = b9;
    hdr[10] = 8'h00;
    hdr[11] = 8'h00;
    for (int i = 0; i < HdrLen; i++) begin
      framed_beats.push_back(beat_t'{data: hdr[i], fin: fin && (i == HdrLen - 1)});
    end
  endfunction

  // predicted beats of one accepted item, appended to framed_beats
  function automatic void frame_item(input framer_item_t it);
    case (it.action)
      ACT_START: begin
        // a new start drops any open message without pads
        msg_left = it.size;
        msg_pads = 2'((WordBytes - it.size[1:0]) % WordBytes);
        msg_open = (it.size != 0);
        push_header(ID_MSG_OUT, it.tag, it.size, it.eom ? ATTR_EOM : 8'h00, 8'h00,
                    it.size == 0);
      end
      ACT_REQUEST: begin
        msg_open = 1'b0;
        msg_left = '0;
        msg_pads = '0;
        push_header(ID_REQ_IN, it.tag, it.size, it.use_tc ? ATTR_TERM : 8'h00,
                    it.use_tc ? it.tchar : 8'h00, 1'b1);
      end
      ACT_BYTE: begin
        // payload outside a message is dropped silently
        if (msg_open && msg_left != 0) begin
          msg_left = msg_left - 1;
          if (msg_left != 0) begin
            framed_beats.push_back(beat_t'{data: it.data, fin: 1'b0});
          end else begin
            // final payload byte, then zero pads up to a word boundary
            framed_beats.push_back(beat_t'{data: it.data, fin: msg_pads == 0});
            for (int p = 0; p < msg_pads; p++) begin
              framed_beats.push_back(beat_t'{data: 8'h00, fin: p == msg_pads - 1});
            end
            msg_pads = '0;
            msg_open = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(input bit owed, input beat_t want, input beat_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReported) begin
      if (!owed) begin
        $display("%0t: beat with nothing owed: byte %02h last %0b", $time, got.data, got.fin);
      end else begin
        $display("%0t: beat mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                 $time, want.data, want.fin, got.data, got.fin);
      end
    end
  endfunction

  // input side first, so a beat's expectation is queued before any output check
  always @(posedge clk_i) begin : scoreboard
    beat_t got;
    beat_t want;
    if (in_valid_i && in_ready_o) begin
      framed_beats.delete();
      frame_item(framer_item_t'{action_i, tag_i, transfer_size_i, end_of_message_i,
                                term_char_i, use_term_char_i, data_byte_i});
      if (row_typed) begin
        for (int i = 0; i < row_n; i++) begin
          owed_beats.push_back(beat_t'{data: row_bytes[95 - 8 * i -: 8],
                                       fin: row_fin && (i == row_n - 1)});
        end
      end else begin
        foreach (framed_beats[i]) owed_beats.push_back(framed_beats[i]);
      end
    end
    if (out_valid_o && out_ready_i) begin
      got = beat_t'{data: out_byte_o, fin: last_o};
      if (owed_beats.size() == 0) begin
        note_mismatch(1'b0, got, got);
      end else begin
        want = owed_beats.pop_front();
        if (got.data !== want.data || got.fin !== want.fin) note_mismatch(1'b1, want, got);
      end
    end
  end

  // every field random, action as given
  function automatic framer_item_t random_item(input logic [1:0] action);
    framer_item_t it;
    it.action = action;
    it.tag    = 8'($urandom);
    it.size   = $urandom;
    it.eom    = 1'($urandom);
    it.tchar  = 8'($urandom);
    it.use_tc = 1'($urandom);
    it.data   = 8'($urandom);
    return it;
  endfunction

  function automatic dir_row_t dir_row(input logic typed, input logic [3:0] n,
                                       input logic [95:0] bytes, input logic fin,
                                       input logic [1:0] action, input logic [7:0] tag,
                                       input logic [31:0] size, input logic eom,
                                       input logic [7:0] tchar, input logic use_tc,
                                       input logic [7:0] data);
    dir_row_t row;
    row.item  = framer_item_t'{action, tag, size, eom, tchar, use_tc, data};
    row.typed = typed;
    row.n     = n;
    row.bytes = bytes;
    row.fin   = fin;
    return row;
  endfunction

  // offer one beat, bursts of random length with random gaps between them
  task automatic send_item(input framer_item_t it, input logic typed = 1'b0,
                           input logic [3:0] n = '0, input logic [95:0] bytes = '0,
                           input logic fin = 1'b0);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      if (in_valid_i) in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i       <= 1'b1;
    action_i         <= it.action;
    tag_i            <= it.tag;
    transfer_size_i  <= it.size;
    end_of_message_i <= it.eom;
    term_char_i      <= it.tchar;
    use_term_char_i  <= it.use_tc;
    data_byte_i      <= it.data;
    row_typed        <= typed;
    row_n            <= n;
    row_bytes        <= bytes;
    row_fin          <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // sender goes quiet until every owed beat has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed_beats.size() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  // receiver: stretches of free flow, light and heavy stalls, one long hold-off
  initial begin : receiver
    int unsigned stretch;
    int unsigned mode;
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      mode    = $urandom_range(0, 2);
      stretch = $urandom_range(20, 120);
      repeat (stretch) begin
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= 1'($urandom);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    dir_row_t     rows [$];
    framer_item_t it;
    int unsigned  sent;
    int unsigned  sz;
    int unsigned  cut;
    int unsigned  pick;
    bit           hold_issued;
    bit           pause_issued;

    // payload byte with no message open, then the unused action code: both silent
    rows.push_back(dir_row(1, 0, '0, 0, ACT_BYTE, 8'h00, 32'h0, 0, 8'h00, 0, 8'hA5));
    rows.push_back(dir_row(1, 0, '0, 0, ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1, 8'hFF, 1, 8'hFF));
    // empty message: header only, last on its twelfth byte
    rows.push_back(dir_row(1, 12, 96'h0100FF00_00000000_01000000, 1,
                           ACT_START, 8'h00, 32'h0, 1, 8'h00, 0, 8'h00));
    // request-in with tag and size at their top, term char 0A in use
    rows.push_back(dir_row(1, 12, 96'h02FF0000_FFFFFFFF_020A0000, 1,
                           ACT_REQUEST, 8'hFF, 32'hFFFF_FFFF, 0, 8'h0A, 1, 8'h00));
    // request-in without term char: attribute and char byte stay zero
    rows.push_back(dir_row(1, 12, 96'h025AA500_00000000_00000000, 1,
                           ACT_REQUEST, 8'h5A, 32'h0, 1, 8'hFF, 0, 8'hFF));
    // one-byte message: header not last, then the byte and three pads
    rows.push_back(dir_row(1, 12, 96'h0101FE00_01000000_00000000, 0,
                           ACT_START, 8'h01, 32'h1, 0, 8'hFF, 1, 8'h00));
    rows.push_back(dir_row(1, 4, 96'hFF000000_00000000_00000000, 1,
                           ACT_BYTE, 8'h00, 32'h0, 0, 8'h00, 0, 8'hFF));
    // message closed, this byte goes nowhere
    rows.push_back(dir_row(1, 0, '0, 0, ACT_BYTE, 8'h12, 32'h4, 1, 8'h00, 1, 8'h00));
    // word-sized message, no pads
    rows.push_back(dir_row(0, 0, '0, 0, ACT_START, 8'h80, 32'h4, 1, 8'h00, 0, 8'h00));
    rows.push_back(dir_row(0, 0, '0, 0, ACT_BYTE, 8'h00, 32'h0, 0, 8'h00, 0, 8'h01));
    rows.push_back(dir_row(0, 0, '0, 0, ACT_BYTE, 8'h00, 32'h0, 0, 8'h00, 0, 8'h80));
    rows.push_back(dir_row(0, 0, '0, 0, ACT_BYTE, 8'h00, 32'h0, 0, 8'h00, 0, 8'h7F));
    rows.push_back(dir_row(0, 0, '0, 0, ACT_BYTE, 8'h00, 32'h0, 0, 8'h00, 0, 8'hFE));
    // two bytes, two pads
    rows.push_back(dir_row(0, 0, '0, 0, ACT_START, 8'h33, 32'h2, 0, 8'h44, 1, 8'h00));
    rows.push_back(dir_row(0, 0, '0, 0, ACT_BYTE, 8'hFF, 32'hFFFF_FFFF, 1, 8'hFF, 1, 8'h00));
    rows.push_back(dir_row(0, 0, '0, 0, ACT_BYTE, 8'h00, 32'h0, 0, 8'h00, 0, 8'hC9));
    // huge message abandoned by a new start, which is abandoned by a request-in
    rows.push_back(dir_row(0, 0, '0, 0, ACT_START, 8'hC3, 32'hFFFF_FFFF, 1, 8'h00, 0, 8'h00));
    rows.push_back(dir_row(0, 0, '0, 0, ACT_BYTE, 8'h00, 32'h0, 0, 8'h00, 0, 8'h55));
    rows.push_back(dir_row(0, 0, '0, 0, ACT_START, 8'h00, 32'h5, 0, 8'h00, 0, 8'h00));
    rows.push_back(dir_row(0, 0, '0, 0, ACT_BYTE, 8'h00, 32'h0, 0, 8'h00, 0, 8'hAA));
    rows.push_back(dir_row(0, 0, '0, 0, ACT_REQUEST, 8'h7E, 32'h0001_0000, 0, 8'h00, 1, 8'h00));
    rows.push_back(dir_row(1, 0, '0, 0, ACT_BYTE, 8'h00, 32'h0, 0, 8'h00, 0, 8'h3C));

    hold_issued  = 1'b0;
    pause_issued = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) send_item(rows[r].item, rows[r].typed, rows[r].n, rows[r].bytes,
                                rows[r].fin);
    wait_idle();

    // random traffic: mostly complete messages, some abandoned ones and noise
    sent = 0;
    while (sent < RandomItems) begin
      if (!hold_issued && sent >= 40) begin
        hold_issued  = 1'b1;
        hold_off_req = 1'b1;
      end
      if (!pause_issued && sent >= 100) begin
        pause_issued = 1'b1;
        wait_idle();
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        sz = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 13);
        it = random_item(ACT_START);
        it.size = sz;
        send_item(it);
        repeat (sz) send_item(random_item(ACT_BYTE));
        sent += 1 + sz;
      end else if (pick < 72) begin
        send_item(random_item(ACT_REQUEST));
        sent++;
      end else if (pick < 84) begin
        // start whose payload is cut short, left open for what follows
        it = random_item(ACT_START);
        if ($urandom_range(0, 1) != 0) it.size = $urandom_range(5, 60);
        cut = $urandom_range(0, 3);
        send_item(it);
        repeat (cut) send_item(random_item(ACT_BYTE));
        sent += 1 + cut;
      end else if (pick < 94) begin
        send_item(random_item(ACT_BYTE));
        sent++;
      end else begin
        send_item(random_item(ACT_UNUSED));
        sent++;
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("bulk_out_transfer_framer regression: pass");
    end else begin
      $display("bulk_out_transfer_framer regression: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin : watchdog
    #(2_000_000);
    $display("bulk_out_transfer_framer regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bof_pkg.sv
rtl/core/bof_front.sv
rtl/core/bof_queue.sv
rtl/core/bof_back.sv
rtl/core/bulk_out_transfer_framer.sv
bench/testbench.sv
